// ===== rtl/hist_eq_pkg.sv =====
`default_nettype none

package hist_eq_pkg;

	localparam int MAX_PIXELS = 1048576;
	localparam int BIN_COUNT  = 256;
	localparam int BIN_W      = $clog2(BIN_COUNT);
	localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
	localparam int NUM_W      = CNT_W + 8;
	localparam int DIV_STEPS  = 9;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_ACCUM = 2'd1;
	localparam logic [1:0] OP_MAP   = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic             rd_en;
		logic [BIN_W-1:0] rd_addr;
		logic             wr_en;
		logic [BIN_W-1:0] wr_addr;
		logic [CNT_W-1:0] wr_data;
		logic             clear;
	} ram_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [CNT_W-1:0] denom;
	} div_req_t;

endpackage

`default_nettype wire

// ===== rtl/histogram_equalizer_unit.sv =====
// Count reads the pixel's bin, then writes it back plus one in the S_CNT state.
// Accumulate makes one read-add-write pass over the 256 bins of the bin memory.
// Map reads the pixel's bin, then runs 9 steps of the serial divider before its result strobe.
// A map with an empty pixel count gives a zero result from S_MAP without the divider; clear empties bins and count.
// Reset is asynchronous and active low; it empties the bins and the count at once.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module histogram_equalizer_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [1:0] opcode,
	input  wire  [7:0] pixel,
	output logic       done,
	output logic [7:0] mapped_pixel
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CNT  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_MAP  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;

	logic [2:0]                          state_q;
	logic [hist_eq_pkg::CNT_W-1:0]       count_q;
	logic [hist_eq_pkg::CNT_W-1:0]       sum_q;
	logic [hist_eq_pkg::BIN_W-1:0]       idx_q;
	logic [7:0]                          px_q;
	logic                                done_q;
	logic [7:0]                          mapped_q;
	logic                                accept;
	logic [hist_eq_pkg::CNT_W-1:0]       rd_data;
	logic [hist_eq_pkg::CNT_W:0]         sum_wide;
	logic [hist_eq_pkg::CNT_W-1:0]       sum_nxt;
	logic                                div_done;
	logic [7:0]                          div_quo;
	hist_eq_pkg::ram_req_t               ram_req;
	hist_eq_pkg::div_req_t               div_req;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;

	assign sum_wide = {1'b0, sum_q} + {1'b0, rd_data};
	assign sum_nxt  = (sum_wide > {1'b0, hist_eq_pkg::MAX_CNT}) ? hist_eq_pkg::MAX_CNT
	                                                            : sum_wide[hist_eq_pkg::CNT_W-1:0];

	always_comb begin
		ram_req = '0;
		div_req = '0;
		div_req.numer = {rd_data, 8'd0} - {8'd0, rd_data};
		div_req.denom = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					ram_req.clear   = opcode == hist_eq_pkg::OP_CLEAR;
					ram_req.rd_en   = opcode != hist_eq_pkg::OP_CLEAR;
					ram_req.rd_addr = (opcode == hist_eq_pkg::OP_ACCUM) ? '0 : pixel;
				end
			end
			S_CNT: begin
				ram_req.wr_en   = count_q < hist_eq_pkg::MAX_CNT;
				ram_req.wr_addr = px_q;
				ram_req.wr_data = (rd_data < hist_eq_pkg::MAX_CNT)
				                  ? rd_data + hist_eq_pkg::CNT_W'(1) : rd_data;
			end
			S_ACC: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = idx_q;
				ram_req.wr_data = sum_nxt;
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = idx_q + hist_eq_pkg::BIN_W'(1);
			end
			S_MAP: begin
				div_req.start = count_q != '0;
			end
			S_DIV: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							hist_eq_pkg::OP_COUNT: state_q <= S_CNT;
							hist_eq_pkg::OP_ACCUM: begin
								state_q <= S_ACC;
								idx_q   <= '0;
							end
							hist_eq_pkg::OP_MAP:   state_q <= S_MAP;
							hist_eq_pkg::OP_CLEAR: count_q <= '0;
						endcase
					end
				end
				S_CNT: begin
					if (count_q < hist_eq_pkg::MAX_CNT) begin
						count_q <= count_q + hist_eq_pkg::CNT_W'(1);
					end
					state_q <= S_IDLE;
				end
				S_ACC: begin
					idx_q <= idx_q + hist_eq_pkg::BIN_W'(1);
					if (idx_q == hist_eq_pkg::BIN_W'(hist_eq_pkg::BIN_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_MAP: begin
					if (count_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q  <= pixel;
			sum_q <= '0;
		end else if (state_q == S_ACC) begin
			sum_q <= sum_nxt;
		end
		if (state_q == S_MAP) begin
			mapped_q <= 8'd0;
		end else if (state_q == S_DIV && div_done) begin
			mapped_q <= div_quo;
		end
	end

	hist_eq_bin_ram u_bin_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	hist_eq_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign done         = done_q;
	assign mapped_pixel = mapped_q;

	a_done_after_map: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_MAP || $past(state_q) == S_DIV))
		else $error("result strobe without a map request");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hist_eq_pkg::MAX_CNT)
		else $error("pixel count above its limit");

	a_acc_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && idx_q != hist_eq_pkg::BIN_W'(hist_eq_pkg::BIN_COUNT - 1))
		|=> (state_q == S_ACC && idx_q == $past(idx_q) + hist_eq_pkg::BIN_W'(1)))
		else $error("accumulate sweep broke off");

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

// ===== rtl/hist_eq_bin_ram.sv =====
`default_nettype none

module hist_eq_bin_ram (
	input  wire                           clk,
	input  wire                           arst_n,
	input  hist_eq_pkg::ram_req_t         req,
	output logic [hist_eq_pkg::CNT_W-1:0] rd_data
);

	logic [hist_eq_pkg::CNT_W-1:0]     mem [hist_eq_pkg::BIN_COUNT];
	logic [hist_eq_pkg::BIN_COUNT-1:0] vld_q;
	logic [hist_eq_pkg::CNT_W-1:0]     rd_data_q;
	logic                              rd_vld_q;

	// A bin that has not been written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clear) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
			rd_vld_q  <= vld_q[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/hist_eq_divider.sv =====
`default_nettype none

module hist_eq_divider (
	input  wire                   clk,
	input  wire                   arst_n,
	input  hist_eq_pkg::div_req_t req,
	output logic                  done,
	output logic [7:0]            quotient
);

	logic                             busy_q;
	logic [hist_eq_pkg::STEP_W-1:0]   step_q;
	logic [hist_eq_pkg::NUM_W-1:0]    rem_q;
	logic [hist_eq_pkg::NUM_W-1:0]    dsh_q;
	logic [7:0]                       quo_q;
	logic                             done_q;
	logic [7:0]                       quotient_q;
	logic                             ge;
	logic [8:0]                       quo_full;

	assign ge       = rem_q >= dsh_q;
	assign quo_full = {quo_q, ge};

	// Restoring division, one quotient bit per cycle; a ninth bit marks overflow.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				step_q <= step_q + hist_eq_pkg::STEP_W'(1);
				if (step_q == hist_eq_pkg::STEP_W'(hist_eq_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= quo_full[7:0];
			quotient_q <= quo_full[8] ? 8'd255 : quo_full[7:0];
		end else if (req.start) begin
			rem_q <= req.numer;
			dsh_q <= {req.denom, 8'd0};
			quo_q <= '0;
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;

endmodule

`default_nettype wire
